>>> rtl/core/ircfd_pkg.sv
`default_nettype none

package ircfd_pkg;

    // Frame layout
    localparam int unsigned FRAME_LEN   = 12;
    localparam int unsigned SUM_LAST    = 10;
    localparam int unsigned CSUM_POS    = 11;
    localparam int unsigned FIFO_DEPTH  = 2;

    // Byte positions that carry fields
    localparam logic [3:0] POS_HEADER = 4'd0;
    localparam logic [3:0] POS_TYPE   = 4'd1;
    localparam logic [3:0] POS_POWER  = 4'd3;
    localparam logic [3:0] POS_MODE   = 4'd4;
    localparam logic [3:0] POS_TEMP   = 4'd5;
    localparam logic [3:0] POS_FAN    = 4'd6;
    localparam logic [3:0] POS_SWING  = 4'd10;
    localparam logic [3:0] POS_CSUM   = 4'd11;
    localparam logic [3:0] COUNT_FULL = 4'd12;

    // Reset values of the configuration registers
    localparam logic [15:0] DEVICE_ADDRESS_RST = 16'hC4D3;
    localparam logic [7:0]  CHECKSUM_BIAS_RST  = 8'hD0;

    // Register indexes on the configuration port
    localparam logic REG_DEVICE_ADDRESS = 1'b0;
    localparam logic REG_CHECKSUM_BIAS  = 1'b1;

    // Frame constants
    localparam logic [7:0] HDR_BYTE    = 8'h64;
    localparam logic [7:0] TYPE_WAKE   = 8'h40;
    localparam logic [7:0] TYPE_DATA   = 8'h80;
    localparam logic [7:0] POWER_BIT   = 8'h20;
    localparam logic [7:0] VSWING_BITS = 8'h0C;
    localparam logic [7:0] HSWING_BIT  = 8'h10;
    localparam logic [7:0] ODD_BIT     = 8'h20;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ADDRESS  = 3'd1,
        ST_SHORT    = 3'd2,
        ST_HEADER   = 3'd3,
        ST_WAKE     = 3'd4,
        ST_UNKNOWN  = 3'd5,
        ST_CHECKSUM = 3'd6,
        ST_BAD_MODE = 3'd7
    } t_status;

    // Mode codes
    localparam logic [2:0] MODE_OFF  = 3'd0;
    localparam logic [2:0] MODE_HEAT = 3'd1;
    localparam logic [2:0] MODE_COOL = 3'd2;
    localparam logic [2:0] MODE_DRY  = 3'd3;
    localparam logic [2:0] MODE_AUTO = 3'd4;
    localparam logic [2:0] MODE_FAN  = 3'd5;

    // Fan codes
    localparam logic [1:0] FAN_AUTO = 2'd0;
    localparam logic [1:0] FAN_LOW  = 2'd1;
    localparam logic [1:0] FAN_MED  = 2'd2;
    localparam logic [1:0] FAN_HIGH = 2'd3;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        frame_first;
        logic        frame_last;
        logic [15:0] frame_address;
    } t_in_req;

    typedef struct packed {
        logic       accepted;
        logic [2:0] status;
        logic [2:0] mode;
        logic [6:0] target_temp_f;
        logic [1:0] fan_speed;
        logic [1:0] swing;
    } t_out_res;

    typedef struct packed {
        logic [15:0] device_address;
        logic [7:0]  checksum_bias;
    } t_cfg;

    // Everything the back end needs about one finished frame
    typedef struct packed {
        logic       address_ok;
        logic       full;
        logic       checksum_ok;
        logic [7:0] header_byte;
        logic [7:0] type_byte;
        logic [7:0] power_byte;
        logic [7:0] mode_byte;
        logic [7:0] temp_byte;
        logic [7:0] fan_byte;
        logic [7:0] swing_byte;
    } t_frame;

    typedef struct packed {
        logic       valid;
        logic [2:0] code;
    } t_mode_dec;

    // Temperature in degrees F by upper nibble of the temperature byte
    function automatic logic [6:0] temp_lut(input logic [3:0] idx);
        logic [6:0] t;
        case (idx)
            4'h0: t = 7'd88;
            4'h1: t = 7'd73;
            4'h2: t = 7'd81;
            4'h3: t = 7'd66;
            4'h4: t = 7'd84;
            4'h5: t = 7'd70;
            4'h6: t = 7'd77;
            4'h7: t = 7'd63;
            4'h8: t = 7'd86;
            4'h9: t = 7'd72;
            4'hA: t = 7'd79;
            4'hB: t = 7'd64;
            4'hC: t = 7'd82;
            4'hD: t = 7'd68;
            4'hE: t = 7'd75;
            4'hF: t = 7'd61;
            default: t = 7'd61;
        endcase
        return t;
    endfunction

    function automatic t_mode_dec mode_decode(input logic [3:0] nib);
        t_mode_dec d;
        d.valid = 1'b1;
        case (nib)
            4'h8: d.code = MODE_HEAT;
            4'hC: d.code = MODE_COOL;
            4'h4: d.code = MODE_DRY;
            4'h1: d.code = MODE_AUTO;
            4'hE: d.code = MODE_FAN;
            default: begin
                d.valid = 1'b0;
                d.code  = MODE_OFF;
            end
        endcase
        return d;
    endfunction

    function automatic logic [1:0] fan_decode(input logic [3:0] nib);
        logic [1:0] f;
        case (nib) inside
            4'h5, 4'h7: f = FAN_LOW;
            4'h9, 4'hD: f = FAN_MED;
            4'hB:       f = FAN_HIGH;
            default:    f = FAN_AUTO;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ircfd_front.sv
`default_nettype none

module ircfd_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_accept,
    input  ircfd_pkg::t_in_req      i_req,
    input  ircfd_pkg::t_cfg         i_cfg,
    output logic                    o_push,
    output ircfd_pkg::t_frame       o_frame
);

    logic [3:0] r_byte_count, n_byte_count;
    logic [7:0] r_running_sum, n_running_sum;
    logic       r_address_ok, n_address_ok;
    logic       r_checksum_ok, n_checksum_ok;
    logic [7:0] r_header_byte, n_header_byte;
    logic [7:0] r_type_byte, n_type_byte;
    logic [7:0] r_power_byte, n_power_byte;
    logic [7:0] r_mode_byte, n_mode_byte;
    logic [7:0] r_temp_byte, n_temp_byte;
    logic [7:0] r_fan_byte, n_fan_byte;
    logic [7:0] r_swing_byte, n_swing_byte;

    logic [3:0] cnt;
    logic [7:0] sum;
    logic [7:0] exp_csum;

    // Frame-start restart, then field capture by byte position
    always_comb begin
        cnt           = i_req.frame_first ? 4'd0 : r_byte_count;
        sum           = i_req.frame_first ? 8'd0 : r_running_sum;
        n_address_ok  = i_req.frame_first ?
                        (i_req.frame_address == i_cfg.device_address) : r_address_ok;
        n_checksum_ok = i_req.frame_first ? 1'b0 : r_checksum_ok;
        n_byte_count  = cnt;
        n_running_sum = sum;
        n_header_byte = r_header_byte;
        n_type_byte   = r_type_byte;
        n_power_byte  = r_power_byte;
        n_mode_byte   = r_mode_byte;
        n_temp_byte   = r_temp_byte;
        n_fan_byte    = r_fan_byte;
        n_swing_byte  = r_swing_byte;
        exp_csum      = (8'd0 - sum) ^ i_cfg.checksum_bias;

        if (cnt < ircfd_pkg::COUNT_FULL) begin
            if (cnt <= ircfd_pkg::POS_SWING) begin
                n_running_sum = sum + i_req.data_byte;
            end
            case (cnt)
                ircfd_pkg::POS_HEADER: n_header_byte = i_req.data_byte;
                ircfd_pkg::POS_TYPE:   n_type_byte   = i_req.data_byte;
                ircfd_pkg::POS_POWER:  n_power_byte  = i_req.data_byte;
                ircfd_pkg::POS_MODE:   n_mode_byte   = i_req.data_byte;
                ircfd_pkg::POS_TEMP:   n_temp_byte   = i_req.data_byte;
                ircfd_pkg::POS_FAN:    n_fan_byte    = i_req.data_byte;
                ircfd_pkg::POS_SWING:  n_swing_byte  = i_req.data_byte;
                ircfd_pkg::POS_CSUM:   n_checksum_ok = (exp_csum == i_req.data_byte);
                default: ;
            endcase
            n_byte_count = cnt + 4'd1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= 4'd0;
            r_running_sum <= 8'd0;
            r_address_ok  <= 1'b0;
            r_checksum_ok <= 1'b0;
        end else if (i_accept) begin
            r_byte_count  <= n_byte_count;
            r_running_sum <= n_running_sum;
            r_address_ok  <= n_address_ok;
            r_checksum_ok <= n_checksum_ok;
        end
    end

    // Captured field bytes
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_header_byte <= n_header_byte;
            r_type_byte   <= n_type_byte;
            r_power_byte  <= n_power_byte;
            r_mode_byte   <= n_mode_byte;
            r_temp_byte   <= n_temp_byte;
            r_fan_byte    <= n_fan_byte;
            r_swing_byte  <= n_swing_byte;
        end
    end

    // Hand the finished frame to the queue on its last byte
    assign o_push = i_accept && i_req.frame_last;

    always_comb begin
        o_frame.address_ok  = n_address_ok;
        o_frame.full        = (n_byte_count == ircfd_pkg::COUNT_FULL);
        o_frame.checksum_ok = n_checksum_ok;
        o_frame.header_byte = n_header_byte;
        o_frame.type_byte   = n_type_byte;
        o_frame.power_byte  = n_power_byte;
        o_frame.mode_byte   = n_mode_byte;
        o_frame.temp_byte   = n_temp_byte;
        o_frame.fan_byte    = n_fan_byte;
        o_frame.swing_byte  = n_swing_byte;
    end

endmodule

`default_nettype wire

>>> rtl/core/ircfd_fifo.sv
`default_nettype none

module ircfd_fifo #(
    parameter int unsigned DEPTH = ircfd_pkg::FIFO_DEPTH
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  ircfd_pkg::t_frame       i_frame,
    input  wire                     i_pop,
    output logic                    o_full,
    output logic                    o_empty,
    output ircfd_pkg::t_frame       o_frame
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ircfd_pkg::t_frame r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_frame = r_mem[r_rd_ptr];

    // Pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ircfd_back.sv
`default_nettype none

module ircfd_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_empty,
    input  ircfd_pkg::t_frame       i_frame,
    output logic                    o_pop,
    input  wire                     i_out_stall,
    output logic                    o_out_valid,
    output ircfd_pkg::t_out_res     o_out_res
);

    logic                   r_valid;
    ircfd_pkg::t_out_res    r_res, n_res;
    ircfd_pkg::t_mode_dec   mdec;

    // Checks in priority order, then field decode
    always_comb begin
        mdec  = ircfd_pkg::mode_decode(i_frame.mode_byte[7:4]);
        n_res = '0;
        if (!i_frame.address_ok) begin
            n_res.status = ircfd_pkg::ST_ADDRESS;
        end else if (!i_frame.full) begin
            n_res.status = ircfd_pkg::ST_SHORT;
        end else if (i_frame.header_byte != ircfd_pkg::HDR_BYTE) begin
            n_res.status = ircfd_pkg::ST_HEADER;
        end else if (i_frame.type_byte == ircfd_pkg::TYPE_WAKE) begin
            n_res.status = ircfd_pkg::ST_WAKE;
        end else if (i_frame.type_byte != ircfd_pkg::TYPE_DATA) begin
            n_res.status = ircfd_pkg::ST_UNKNOWN;
        end else if (!i_frame.checksum_ok) begin
            n_res.status = ircfd_pkg::ST_CHECKSUM;
        end else if (!mdec.valid) begin
            n_res.status = ircfd_pkg::ST_BAD_MODE;
        end else begin
            n_res.accepted = 1'b1;
            n_res.status   = ircfd_pkg::ST_OK;
            // power bit clear forces off
            n_res.mode     = |(i_frame.power_byte & ircfd_pkg::POWER_BIT) ?
                             mdec.code : ircfd_pkg::MODE_OFF;
            n_res.target_temp_f = ircfd_pkg::temp_lut(i_frame.temp_byte[7:4])
                                + {6'd0, |(i_frame.swing_byte & ircfd_pkg::ODD_BIT)};
            n_res.fan_speed = ircfd_pkg::fan_decode(i_frame.fan_byte[7:4]);
            n_res.swing     = {|(i_frame.swing_byte & ircfd_pkg::HSWING_BIT),
                               |(i_frame.fan_byte & ircfd_pkg::VSWING_BITS)};
        end
    end

    // Output register: load when empty or being taken
    assign o_pop = !i_empty && (!r_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_res   = r_res;

endmodule

`default_nettype wire

>>> rtl/core/ir_climate_frame_decoder_core.sv
`default_nettype none

// Infrared climate frame decoder. Takes one demodulated frame byte per request
// with the frame address, and on the byte marked last gives one result: a status
// code and, for an accepted frame, mode, target temperature in degrees F, fan speed
// and swing. One byte is accepted every clock while input stall is low; the front
// end folds each byte into the running sum and field registers in that cycle, and
// the finished frame passes through a small queue to the decode stage, whose
// output register loads at the earliest at the clock edge after the one that
// accepts the last byte. Input stall rises only when that queue is full because
// results are held back downstream. Registers: device address at byte address 0,
// checksum bias at byte address 4; write them only while idle.
module ir_climate_frame_decoder_core #(
    parameter int unsigned FIFO_DEPTH = ircfd_pkg::FIFO_DEPTH
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // input requests
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  ircfd_pkg::t_in_req      i_in_req,
    // results
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output ircfd_pkg::t_out_res     o_out_res,
    // configuration port
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [2:0]              paddr,
    input  wire  [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    ircfd_pkg::t_cfg    r_cfg;
    ircfd_pkg::t_frame  front_frame;
    ircfd_pkg::t_frame  fifo_frame;
    logic               in_accept;
    logic               push;
    logic               pop;
    logic               fifo_full;
    logic               fifo_empty;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= ircfd_pkg::DEVICE_ADDRESS_RST;
            r_cfg.checksum_bias  <= ircfd_pkg::CHECKSUM_BIAS_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                ircfd_pkg::REG_DEVICE_ADDRESS: r_cfg.device_address <= pwdata[15:0];
                ircfd_pkg::REG_CHECKSUM_BIAS:  r_cfg.checksum_bias  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ircfd_pkg::REG_CHECKSUM_BIAS) ?
                    {24'd0, r_cfg.checksum_bias} : {16'd0, r_cfg.device_address};

    assign o_in_stall = fifo_full;
    assign in_accept  = i_in_valid && !o_in_stall;

    ircfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_req    (i_in_req),
        .i_cfg    (r_cfg),
        .o_push   (push),
        .o_frame  (front_frame)
    );

    ircfd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (front_frame),
        .i_pop   (pop),
        .o_full  (fifo_full),
        .o_empty (fifo_empty),
        .o_frame (fifo_frame)
    );

    ircfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (fifo_empty),
        .i_frame     (fifo_frame),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

endmodule

`default_nettype wire

>>> rtl/core/ircfd_checker.sv
`default_nettype none

module ircfd_checker (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     o_out_valid,
    input  wire                     i_out_stall,
    input  ircfd_pkg::t_out_res     o_out_res,
    input  wire                     pready
);

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_res))
        else $error("stalled result changed");

    // Accepted flag and status agree
    a_acc_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_res.accepted == (o_out_res.status == ircfd_pkg::ST_OK)))
        else $error("accepted flag disagrees with status");

    // Rejected frames carry zero fields
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_res.accepted |->
            o_out_res.mode == ircfd_pkg::MODE_OFF && o_out_res.target_temp_f == 7'd0 &&
            o_out_res.fan_speed == ircfd_pkg::FAN_AUTO && o_out_res.swing == 2'd0)
        else $error("rejected frame with nonzero fields");

    // Accepted frames have a legal mode and temperature
    a_accept_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.accepted |->
            o_out_res.mode <= ircfd_pkg::MODE_FAN &&
            o_out_res.target_temp_f >= 7'd61 && o_out_res.target_temp_f <= 7'd89)
        else $error("accepted frame out of range");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind ir_climate_frame_decoder_core ircfd_checker u_ircfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_res   (o_out_res),
    .pready      (pready)
);

`default_nettype wire

>>> dv/tb_ir_climate_frame_decoder_core.sv
`default_nettype none

module tb_ir_climate_frame_decoder_core;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_BYTES   = 235;
    localparam int LONG_HOLD     = 400;

    // Upper nibbles of the mode byte that name a mode
    localparam logic [3:0] NIB_HEAT = 4'h8;
    localparam logic [3:0] NIB_COOL = 4'hC;
    localparam logic [3:0] NIB_DRY  = 4'h4;
    localparam logic [3:0] NIB_AUTO = 4'h1;
    localparam logic [3:0] NIB_FAN  = 4'hE;

    // Upper nibbles of the fan byte that name a speed
    localparam logic [3:0] FNIB_LOW_A  = 4'h5;
    localparam logic [3:0] FNIB_LOW_B  = 4'h7;
    localparam logic [3:0] FNIB_MED_A  = 4'h9;
    localparam logic [3:0] FNIB_MED_B  = 4'hD;
    localparam logic [3:0] FNIB_HIGH   = 4'hB;

    typedef logic [7:0] t_byte_q [$];

    // Frame decode predictor and result checker
    class t_climate_scoreboard;
        logic [15:0] dev_address;
        logic [7:0]  sum_bias;
        logic [3:0]  byte_count;
        logic [7:0]  byte_sum;
        bit          addr_match;
        bit          csum_match;
        logic [7:0]  hdr_b, type_b, power_b, mode_b, temp_b, fan_b, swing_b;
        ircfd_pkg::t_out_res expected_results[$];
        int          mismatches;
        int          bytes_seen;
        int          results_seen;
        int          frames_ok;
        int          status_hits[8];

        function new();
            dev_address = ircfd_pkg::DEVICE_ADDRESS_RST;
            sum_bias    = ircfd_pkg::CHECKSUM_BIAS_RST;
            byte_count  = '0;
            byte_sum    = '0;
            addr_match  = 1'b0;
            csum_match  = 1'b0;
            hdr_b       = '0;
            type_b      = '0;
            power_b     = '0;
            mode_b      = '0;
            temp_b      = '0;
            fan_b       = '0;
            swing_b     = '0;
            mismatches  = 0;
            bytes_seen  = 0;
            results_seen = 0;
            frames_ok   = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == ircfd_pkg::REG_DEVICE_ADDRESS) begin
                dev_address = value[15:0];
            end else begin
                sum_bias = value[7:0];
            end
        endfunction

        function logic [6:0] fahrenheit_of(logic [3:0] nib);
            case (nib)
                4'h0: return 7'd88;
                4'h1: return 7'd73;
                4'h2: return 7'd81;
                4'h3: return 7'd66;
                4'h4: return 7'd84;
                4'h5: return 7'd70;
                4'h6: return 7'd77;
                4'h7: return 7'd63;
                4'h8: return 7'd86;
                4'h9: return 7'd72;
                4'hA: return 7'd79;
                4'hB: return 7'd64;
                4'hC: return 7'd82;
                4'hD: return 7'd68;
                4'hE: return 7'd75;
                default: return 7'd61;
            endcase
        endfunction

        function logic [1:0] fan_speed_of(logic [3:0] nib);
            case (nib)
                FNIB_LOW_A, FNIB_LOW_B: return ircfd_pkg::FAN_LOW;
                FNIB_MED_A, FNIB_MED_B: return ircfd_pkg::FAN_MED;
                FNIB_HIGH:              return ircfd_pkg::FAN_HIGH;
                default:                return ircfd_pkg::FAN_AUTO;
            endcase
        endfunction

        // Fold one accepted byte into the frame state; the last byte queues a result
        function void note_request(ircfd_pkg::t_in_req r);
            ircfd_pkg::t_out_res res;
            ircfd_pkg::t_status  st;
            logic [2:0] mcode;
            bit         mvalid;
            logic [7:0] seal;
            bytes_seen++;
            if (r.frame_first) begin
                byte_count = '0;
                byte_sum   = '0;
                addr_match = (r.frame_address == dev_address);
                csum_match = 1'b0;
            end
            if (byte_count < ircfd_pkg::COUNT_FULL) begin
                if (byte_count <= 4'(ircfd_pkg::SUM_LAST)) byte_sum = byte_sum + r.data_byte;
                case (byte_count)
                    ircfd_pkg::POS_HEADER: hdr_b   = r.data_byte;
                    ircfd_pkg::POS_TYPE:   type_b  = r.data_byte;
                    ircfd_pkg::POS_POWER:  power_b = r.data_byte;
                    ircfd_pkg::POS_MODE:   mode_b  = r.data_byte;
                    ircfd_pkg::POS_TEMP:   temp_b  = r.data_byte;
                    ircfd_pkg::POS_FAN:    fan_b   = r.data_byte;
                    ircfd_pkg::POS_SWING:  swing_b = r.data_byte;
                    ircfd_pkg::POS_CSUM: begin
                        seal = (~byte_sum + 8'd1) ^ sum_bias;
                        csum_match = (seal == r.data_byte);
                    end
                    default: ;
                endcase
                byte_count = byte_count + 4'd1;
            end
            if (!r.frame_last) return;

            mvalid = 1'b1;
            case (mode_b[7:4])
                NIB_HEAT: mcode = ircfd_pkg::MODE_HEAT;
                NIB_COOL: mcode = ircfd_pkg::MODE_COOL;
                NIB_DRY:  mcode = ircfd_pkg::MODE_DRY;
                NIB_AUTO: mcode = ircfd_pkg::MODE_AUTO;
                NIB_FAN:  mcode = ircfd_pkg::MODE_FAN;
                default: begin
                    mvalid = 1'b0;
                    mcode  = ircfd_pkg::MODE_OFF;
                end
            endcase

            // first failing check wins
            if (!addr_match)                            st = ircfd_pkg::ST_ADDRESS;
            else if (byte_count < ircfd_pkg::COUNT_FULL) st = ircfd_pkg::ST_SHORT;
            else if (hdr_b != ircfd_pkg::HDR_BYTE)      st = ircfd_pkg::ST_HEADER;
            else if (type_b == ircfd_pkg::TYPE_WAKE)    st = ircfd_pkg::ST_WAKE;
            else if (type_b != ircfd_pkg::TYPE_DATA)    st = ircfd_pkg::ST_UNKNOWN;
            else if (!csum_match)                       st = ircfd_pkg::ST_CHECKSUM;
            else if (!mvalid)                           st = ircfd_pkg::ST_BAD_MODE;
            else                                        st = ircfd_pkg::ST_OK;

            res = '0;
            res.status = st;
            if (st == ircfd_pkg::ST_OK) begin
                res.accepted      = 1'b1;
                res.mode          = ((power_b & ircfd_pkg::POWER_BIT) != 0) ?
                                    mcode : ircfd_pkg::MODE_OFF;
                res.target_temp_f = fahrenheit_of(temp_b[7:4]) +
                                    7'((swing_b & ircfd_pkg::ODD_BIT) != 0);
                res.fan_speed     = fan_speed_of(fan_b[7:4]);
                res.swing         = {(swing_b & ircfd_pkg::HSWING_BIT) != 0,
                                     (fan_b & ircfd_pkg::VSWING_BITS) != 0};
            end
            expected_results.push_back(res);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("MISMATCH at result %0d: %s", results_seen, what);
        endtask

        task compare_field(string name, logic [6:0] got, logic [6:0] want);
            if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        task check_result(ircfd_pkg::t_out_res got);
            ircfd_pkg::t_out_res want;
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with no frame pending");
                return;
            end
            want = expected_results.pop_front();
            compare_field("accepted", 7'(got.accepted), 7'(want.accepted));
            compare_field("status", 7'(got.status), 7'(want.status));
            compare_field("mode", 7'(got.mode), 7'(want.mode));
            compare_field("target_temp_f", got.target_temp_f, want.target_temp_f);
            compare_field("fan_speed", 7'(got.fan_speed), 7'(want.fan_speed));
            compare_field("swing", 7'(got.swing), 7'(want.swing));
            if (want.accepted) frames_ok++;
            status_hits[want.status]++;
        endtask
    endclass

    // DUT connections, inputs known from time zero
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    ircfd_pkg::t_in_req  i_in_req    = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    ircfd_pkg::t_out_res o_out_res;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [2:0]          paddr       = '0;
    logic [31:0]         pwdata      = '0;
    logic [31:0]         prdata;
    logic                pready;

    t_climate_scoreboard sb = new();

    int gap_pct     = 0;
    int stall_pct   = 0;
    int hold_left   = 0;
    int items_sent  = 0;
    int unsigned cycle_count = 0;

    ir_climate_frame_decoder_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 20-unit clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ir_climate_frame_decoder_core: mismatch");
            $finish;
        end
    end

    // Receiver: long hold-off when asked, else random stall
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Handshake monitor; pre-edge values decide each transfer
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_request(i_in_req);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_res);
    end

    task automatic write_register(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
    endtask

    // One request, held until the block takes it
    task automatic send_byte(input ircfd_pkg::t_in_req r);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_frame(input t_byte_q q, input logic [15:0] addr, input bit mark_first);
        ircfd_pkg::t_in_req r;
        for (int i = 0; i < q.size(); i++) begin
            r.data_byte     = q[i];
            r.frame_first   = mark_first && (i == 0);
            r.frame_last    = (i == q.size() - 1);
            r.frame_address = (i == 0) ? addr : 16'($urandom);
            send_byte(r);
        end
    endtask

    // Sender stops until every queued result has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic bit known_mode_nibble(input logic [3:0] nib);
        return nib == NIB_HEAT || nib == NIB_COOL || nib == NIB_DRY ||
               nib == NIB_AUTO || nib == NIB_FAN;
    endfunction

    function automatic void seal_frame(ref t_byte_q q, input logic [7:0] bias);
        logic [7:0] sum;
        sum = '0;
        for (int i = 0; i <= ircfd_pkg::SUM_LAST; i++) sum = sum + q[i];
        q[ircfd_pkg::CSUM_POS] = (~sum + 8'd1) ^ bias;
    endfunction

    // Twelve-byte frame with correct header, type and checksum; random content, mostly a known mode
    function automatic t_byte_q random_frame();
        t_byte_q    q;
        logic [3:0] nib;
        for (int i = 0; i < ircfd_pkg::FRAME_LEN; i++) q.push_back(8'($urandom));
        q[ircfd_pkg::POS_HEADER] = ircfd_pkg::HDR_BYTE;
        q[ircfd_pkg::POS_TYPE]   = ircfd_pkg::TYPE_DATA;
        nib = 4'($urandom);
        if ($urandom_range(99) < 85) begin
            while (!known_mode_nibble(nib)) nib = 4'($urandom);
        end
        q[ircfd_pkg::POS_MODE] = {nib, 4'($urandom)};
        seal_frame(q, sb.sum_bias);
        return q;
    endfunction

    task automatic send_random_frame();
        t_byte_q     q;
        logic [15:0] addr;
        logic [3:0]  nib;
        int          kind;
        int          n;
        bit          mark_first;
        q          = random_frame();
        addr       = sb.dev_address;
        mark_first = 1'b1;
        kind       = $urandom_range(99);
        if (kind < 55) begin
            // good frame, sometimes with trailing bytes
            if ($urandom_range(99) < 15) repeat ($urandom_range(1, 3)) q.push_back(8'($urandom));
        end else if (kind < 62) begin
            addr = addr ^ 16'($urandom_range(1, 65535));
        end else if (kind < 68) begin
            n = $urandom_range(1, ircfd_pkg::FRAME_LEN - 1);
            while (q.size() > n) void'(q.pop_back());
        end else if (kind < 72) begin
            q[ircfd_pkg::POS_HEADER] = q[ircfd_pkg::POS_HEADER] ^ 8'($urandom_range(1, 255));
            seal_frame(q, sb.sum_bias);
        end else if (kind < 76) begin
            q[ircfd_pkg::POS_TYPE] = ircfd_pkg::TYPE_WAKE;
            seal_frame(q, sb.sum_bias);
        end else if (kind < 80) begin
            q[ircfd_pkg::POS_TYPE] = 8'($urandom);
            if (q[ircfd_pkg::POS_TYPE] == ircfd_pkg::TYPE_DATA ||
                q[ircfd_pkg::POS_TYPE] == ircfd_pkg::TYPE_WAKE) begin
                q[ircfd_pkg::POS_TYPE] = ~q[ircfd_pkg::POS_TYPE];
            end
            seal_frame(q, sb.sum_bias);
        end else if (kind < 86) begin
            q[ircfd_pkg::CSUM_POS] = q[ircfd_pkg::CSUM_POS] ^ 8'($urandom_range(1, 255));
        end else if (kind < 90) begin
            nib = 4'($urandom);
            while (known_mode_nibble(nib)) nib = 4'($urandom);
            q[ircfd_pkg::POS_MODE] = {nib, 4'($urandom)};
            seal_frame(q, sb.sum_bias);
        end else begin
            // noise: random bytes, some without a first mark
            mark_first = (kind >= 95);
            n = $urandom_range(1, 16);
            q.delete();
            repeat (n) q.push_back(8'($urandom));
            if ($urandom_range(1)) addr = 16'($urandom);
        end
        send_frame(q, addr, mark_first);
    endtask

    task automatic run_phase(input int hold_at, input bit pause_mid);
        int start;
        bit held;
        bit paused;
        start  = items_sent;
        held   = 1'b0;
        paused = 1'b0;
        while (items_sent - start < PHASE_BYTES) begin
            if (hold_at >= 0 && !held && items_sent - start >= hold_at) begin
                hold_left = LONG_HOLD;
                held = 1'b1;
            end
            if (pause_mid && !paused && items_sent - start >= PHASE_BYTES / 2) begin
                drain_results();
                paused = 1'b1;
            end
            send_random_frame();
        end
    endtask

    task automatic settle_and_configure(input logic [15:0] addr, input logic [7:0] bias,
                                        input int gap, input int stall);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_register(ircfd_pkg::REG_DEVICE_ADDRESS, 32'(addr));
        write_register(ircfd_pkg::REG_CHECKSUM_BIAS, 32'(bias));
        gap_pct   = gap;
        stall_pct = stall;
    endtask

    initial begin
        t_byte_q            q;
        ircfd_pkg::t_in_req r;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: last byte with no first mark right after reset
        r = '{data_byte: 8'hFF, frame_first: 1'b0, frame_last: 1'b1, frame_address: 16'hFFFF};
        send_byte(r);
        // one-byte frames: short, then wrong address
        r = '{data_byte: 8'h00, frame_first: 1'b1, frame_last: 1'b1,
              frame_address: ircfd_pkg::DEVICE_ADDRESS_RST};
        send_byte(r);
        r = '{data_byte: 8'h55, frame_first: 1'b1, frame_last: 1'b1,
              frame_address: ~ircfd_pkg::DEVICE_ADDRESS_RST};
        send_byte(r);
        // power off with cool mode, coldest setting, high fan, both swings, one extra byte
        q = random_frame();
        q[2] = 8'hFF;
        q[ircfd_pkg::POS_POWER] = 8'h00;
        q[ircfd_pkg::POS_MODE]  = {NIB_COOL, 4'hF};
        q[ircfd_pkg::POS_TEMP]  = 8'hF0;
        q[ircfd_pkg::POS_FAN]   = {FNIB_HIGH, 4'hC};
        q[ircfd_pkg::POS_SWING] = ircfd_pkg::ODD_BIT | ircfd_pkg::HSWING_BIT;
        seal_frame(q, sb.sum_bias);
        q.push_back(8'hFF);
        send_frame(q, ircfd_pkg::DEVICE_ADDRESS_RST, 1'b1);
        // power on, fan-only mode, warmest setting
        q = random_frame();
        q[ircfd_pkg::POS_POWER] = ircfd_pkg::POWER_BIT;
        q[ircfd_pkg::POS_MODE]  = {NIB_FAN, 4'h0};
        q[ircfd_pkg::POS_TEMP]  = 8'h00;
        q[ircfd_pkg::POS_FAN]   = 8'h00;
        q[ircfd_pkg::POS_SWING] = ircfd_pkg::ODD_BIT;
        seal_frame(q, sb.sum_bias);
        send_frame(q, ircfd_pkg::DEVICE_ADDRESS_RST, 1'b1);

        // Random phases over register extremes and idle patterns
        settle_and_configure(16'h0000, 8'h00, 0, 0);
        run_phase(100, 1'b0);
        settle_and_configure(16'hFFFF, 8'hFF, 63, 0);
        run_phase(-1, 1'b0);
        settle_and_configure(16'($urandom), 8'($urandom), 0, 63);
        run_phase(-1, 1'b1);
        settle_and_configure(ircfd_pkg::DEVICE_ADDRESS_RST, ircfd_pkg::CHECKSUM_BIAS_RST,
                             36, 36);
        run_phase(-1, 1'b0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d request bytes and %0d frame results (%0d accepted) over four",
                 sb.bytes_seen, sb.results_seen, sb.frames_ok);
        $display({"register settings; rejects addr %0d short %0d hdr %0d wake %0d",
                  " type %0d csum %0d mode %0d"},
                 sb.status_hits[ircfd_pkg::ST_ADDRESS], sb.status_hits[ircfd_pkg::ST_SHORT],
                 sb.status_hits[ircfd_pkg::ST_HEADER], sb.status_hits[ircfd_pkg::ST_WAKE],
                 sb.status_hits[ircfd_pkg::ST_UNKNOWN], sb.status_hits[ircfd_pkg::ST_CHECKSUM],
                 sb.status_hits[ircfd_pkg::ST_BAD_MODE]);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("ir_climate_frame_decoder_core: match");
        end else begin
            $display("ir_climate_frame_decoder_core: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
